[rtl/mlrq_pkg.sv]
// types and constants shared by the ready queue scheduler modules
// no dependencies
package mlrq_pkg;

   localparam int unsigned OpWidth      = 2;
   localparam int unsigned IdWidth      = 8;
   localparam int unsigned PrioWidth    = 8;
   localparam int unsigned BurstWidth   = 16;
   localparam int unsigned WaitWidth    = 10;
   localparam int unsigned SeqWidth     = 8;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned LevelWidth   = 2;
   localparam int unsigned CountWidth   = 5;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 10;

   localparam logic [PrioWidth-1:0] PrioLimit = 8'd150;
   localparam logic [PrioWidth-1:0] PrioMax   = 8'd149;
   localparam logic [WaitWidth-1:0] WaitMax   = 10'd1023;

   typedef enum logic [OpWidth-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_AGE     = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_PRIO  = 2'd3
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_AGING_STEP      = 3'd0,
      CSR_AGING_THRESHOLD = 3'd1,
      CSR_PRIORITY_BOOST  = 3'd2,
      CSR_PRIORITY_CAP    = 3'd3,
      CSR_LEVEL_ONE_FLOOR = 3'd4,
      CSR_LEVEL_TWO_FLOOR = 3'd5
   } csr_idx_type;

   localparam logic [LevelWidth-1:0] LevelNone  = 2'd0;
   localparam logic [LevelWidth-1:0] LevelOne   = 2'd1;
   localparam logic [LevelWidth-1:0] LevelTwo   = 2'd2;
   localparam logic [LevelWidth-1:0] LevelThree = 2'd3;

   typedef enum logic [1:0] {
      SCAN_BEST = 2'd0,
      SCAN_PEND = 2'd1,
      SCAN_WAIT = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic          load;
      logic          clear_best;
      logic          rd_en;
      scan_mode_type mode;
      logic          enq_commit;
      logic          deq_commit;
      logic          promote_commit;
   } cmd_type;

   typedef struct packed {
      logic any_pending;
   } stat_type;

   function automatic logic [LevelWidth-1:0] level_of(
      input logic [PrioWidth-1:0] prio,
      input logic [PrioWidth-1:0] floor_one,
      input logic [PrioWidth-1:0] floor_two);
      logic [LevelWidth-1:0] lvl;
      if (prio >= floor_one) lvl = LevelOne;
      else if (prio >= floor_two) lvl = LevelTwo;
      else lvl = LevelThree;
      return lvl;
   endfunction

endpackage

[rtl/mlrq_req_if.sv]
// request channel interface of the ready queue scheduler
// depends on mlrq_pkg
interface mlrq_req_if;
   logic                      valid;
   logic                      ready;
   mlrq_pkg::op_type          op;
   logic [7:0]                task_id;
   logic [7:0]                task_priority;
   logic [15:0]               task_burst;

   modport source(output valid, op, task_id, task_priority, task_burst, input ready);
   modport sink(input valid, op, task_id, task_priority, task_burst, output ready);
endinterface

[rtl/mlrq_rsp_if.sv]
// response channel interface of the ready queue scheduler
// depends on mlrq_pkg
interface mlrq_rsp_if;
   logic                      valid;
   logic                      ready;
   mlrq_pkg::status_type      status;
   logic [7:0]                out_id;
   logic [7:0]                out_priority;
   logic [15:0]               out_burst;
   logic [1:0]                out_level;
   logic [4:0]                promoted_count;

   modport source(output valid, status, out_id, out_priority, out_burst, out_level,
                  promoted_count, input ready);
   modport sink(input valid, status, out_id, out_priority, out_burst, out_level,
                promoted_count, output ready);
endinterface

[rtl/mlrq_ctrl.sv]
// sequencing state machine of the ready queue scheduler
// depends on mlrq_pkg
module mlrq_ctrl #(
   parameter int unsigned TABLE_ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  mlrq_pkg::op_type                  req_op,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mlrq_pkg::cmd_type                 cmd,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  rd_idx,
   input  mlrq_pkg::stat_type                stat
);
   import mlrq_pkg::*;

   localparam int unsigned IdxWidth = $clog2(TABLE_ENTRIES);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_ENQ, S_SCAN, S_DRAIN, S_DEQ, S_CHECK, S_PROMOTE, S_RESP
   } state_type;

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   scan_mode_type mode_ff, mode_in;
   logic [IdxWidth-1:0] cnt_ff, cnt_in;
   logic          accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rd_idx    = cnt_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mode = mode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               cnt_in   = '0;
               unique case (req_op)
                  OP_ENQUEUE: state_in = S_ENQ;
                  OP_DEQUEUE: begin
                     cmd.clear_best = 1'b1;
                     mode_in        = SCAN_BEST;
                     state_in       = S_SCAN;
                  end
                  OP_AGE: begin
                     mode_in  = SCAN_WAIT;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_ENQ: begin
            cmd.enq_commit = 1'b1;
            state_in       = S_RESP;
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LastIdx) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (op_ff == OP_DEQUEUE) state_in = S_DEQ;
            else if (mode_ff == SCAN_WAIT) state_in = S_CHECK;
            else state_in = S_PROMOTE;
         end
         S_DEQ: begin
            cmd.deq_commit = 1'b1;
            state_in       = S_RESP;
         end
         S_PROMOTE: begin
            cmd.promote_commit = 1'b1;
            state_in           = S_CHECK;
         end
         S_CHECK: begin
            if (stat.any_pending) begin
               cmd.clear_best = 1'b1;
               mode_in        = SCAN_PEND;
               cnt_in         = '0;
               state_in       = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_NONE;
         mode_ff  <= SCAN_BEST;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/mlrq_dpath.sv]
// task table, registers, scan compare and result registers
// depends on mlrq_pkg
module mlrq_dpath #(
   parameter int unsigned TABLE_ENTRIES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mlrq_pkg::cmd_type                     cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]      rd_idx,
   output mlrq_pkg::stat_type                    stat,
   input  logic [7:0]                            in_id,
   input  logic [7:0]                            in_priority,
   input  logic [15:0]                           in_burst,
   input  logic                                  csr_we,
   input  logic [mlrq_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [mlrq_pkg::CsrDataWidth-1:0]     csr_wdata,
   output mlrq_pkg::status_type                  res_status,
   output logic [7:0]                            res_id,
   output logic [7:0]                            res_priority,
   output logic [15:0]                           res_burst,
   output logic [1:0]                            res_level,
   output logic [4:0]                            res_count
);
   import mlrq_pkg::*;

   localparam int unsigned IdxWidth = $clog2(TABLE_ENTRIES);

   // configuration
   logic [7:0]           step_ff;
   logic [WaitWidth-1:0] thr_ff;
   logic [5:0]           boost_ff;
   logic [PrioWidth-1:0] cap_ff, floor1_ff, floor2_ff;

   // table
   logic [IdWidth-1:0]    mem_id    [TABLE_ENTRIES];
   logic [PrioWidth-1:0]  mem_prio  [TABLE_ENTRIES];
   logic [BurstWidth-1:0] mem_burst [TABLE_ENTRIES];
   logic [WaitWidth-1:0]  mem_wait  [TABLE_ENTRIES];
   logic [SeqWidth-1:0]   mem_seq   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in, pend_ff, pend_in;

   // read stage
   logic [IdWidth-1:0]    rd_id_ff;
   logic [PrioWidth-1:0]  rd_prio_ff;
   logic [BurstWidth-1:0] rd_burst_ff;
   logic [WaitWidth-1:0]  rd_wait_ff;
   logic [SeqWidth-1:0]   rd_seq_ff;
   logic                  rd_vld_ff;
   logic [IdxWidth-1:0]   idx_q_ff;
   scan_mode_type         mode_q_ff;

   // latched request and sequence state
   logic [IdWidth-1:0]    tid_ff;
   logic [PrioWidth-1:0]  tpr_ff;
   logic [BurstWidth-1:0] tbu_ff;
   logic [SeqWidth-1:0]   base_ff, nseq_ff, nseq_in;

   // running best
   logic                  best_found_ff, best_found_in;
   logic [IdxWidth-1:0]   best_idx_ff, best_idx_in;
   logic [IdWidth-1:0]    best_id_ff, best_id_in;
   logic [PrioWidth-1:0]  best_prio_ff, best_prio_in;
   logic [BurstWidth-1:0] best_burst_ff, best_burst_in;
   logic [SeqWidth-1:0]   best_seq_ff, best_seq_in;

   // result
   status_type            res_status_ff, res_status_in;
   logic [IdWidth-1:0]    res_id_ff, res_id_in;
   logic [PrioWidth-1:0]  res_prio_ff, res_prio_in;
   logic [BurstWidth-1:0] res_burst_ff, res_burst_in;
   logic [LevelWidth-1:0] res_level_ff, res_level_in;
   logic [CountWidth-1:0] res_count_ff, res_count_in;

   // write port
   logic                  wr_all, wr_wait, wr_prio_seq;
   logic [IdxWidth-1:0]   wr_addr;
   logic [WaitWidth-1:0]  wr_wait_val;
   logic [PrioWidth-1:0]  wr_prio_val;
   logic [SeqWidth-1:0]   wr_seq_val;

   // helpers
   logic                  free_found;
   logic [IdxWidth-1:0]   free_idx;
   logic                  cand_ok, cand_before;
   logic [LevelWidth-1:0] lvl_c, lvl_b;
   logic [SeqWidth-1:0]   age_c, age_b;
   logic [WaitWidth:0]    wait_sum;
   logic                  promote_now;
   logic [PrioWidth-1:0]  cap_eff;
   logic [PrioWidth:0]    prio_sum;

   assign stat.any_pending = |pend_ff;

   assign res_status   = res_status_ff;
   assign res_id       = res_id_ff;
   assign res_priority = res_prio_ff;
   assign res_burst    = res_burst_ff;
   assign res_level    = res_level_ff;
   assign res_count    = res_count_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IdxWidth'(i);
         end
      end
   end

   // ordering compare of the slot just read against the running best
   always_comb begin
      lvl_c = level_of(rd_prio_ff, floor1_ff, floor2_ff);
      lvl_b = level_of(best_prio_ff, floor1_ff, floor2_ff);
      age_c = base_ff - 8'd1 - rd_seq_ff;
      age_b = base_ff - 8'd1 - best_seq_ff;
      if (lvl_c != lvl_b) cand_before = (lvl_c < lvl_b);
      else if (lvl_c == LevelOne && rd_burst_ff != best_burst_ff)
         cand_before = (rd_burst_ff < best_burst_ff);
      else if (lvl_c == LevelTwo && rd_id_ff != best_id_ff)
         cand_before = (rd_id_ff < best_id_ff);
      else cand_before = (age_c > age_b);
      cand_ok = rd_vld_ff && valid_ff[idx_q_ff] &&
                ((mode_q_ff != SCAN_PEND) || pend_ff[idx_q_ff]);
   end

   always_comb begin
      wait_sum    = {1'b0, rd_wait_ff} + (WaitWidth + 1)'(step_ff);
      promote_now = (rd_wait_ff >= thr_ff);
      cap_eff     = (cap_ff > PrioMax) ? PrioMax : cap_ff;
      prio_sum    = {1'b0, best_prio_ff} + (PrioWidth + 1)'(boost_ff);
   end

   always_comb begin
      valid_in      = valid_ff;
      pend_in       = pend_ff;
      nseq_in       = nseq_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_prio_in  = best_prio_ff;
      best_burst_in = best_burst_ff;
      best_seq_in   = best_seq_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_prio_in   = res_prio_ff;
      res_burst_in  = res_burst_ff;
      res_level_in  = res_level_ff;
      res_count_in  = res_count_ff;
      wr_all        = 1'b0;
      wr_wait       = 1'b0;
      wr_prio_seq   = 1'b0;
      wr_addr       = idx_q_ff;
      wr_wait_val   = '0;
      wr_prio_val   = tpr_ff;
      wr_seq_val    = nseq_ff;

      if (cmd.load) begin
         res_status_in = ST_OK;
         res_id_in     = '0;
         res_prio_in   = '0;
         res_burst_in  = '0;
         res_level_in  = LevelNone;
         res_count_in  = '0;
      end
      if (cmd.clear_best) best_found_in = 1'b0;

      // data phase of a scan
      if (cand_ok) begin
         if (mode_q_ff == SCAN_WAIT) begin
            wr_wait = 1'b1;
            if (promote_now) begin
               wr_wait_val = '0;
               pend_in[idx_q_ff] = 1'b1;
            end else begin
               wr_wait_val = (wait_sum > (WaitWidth + 1)'(WaitMax)) ? WaitMax
                             : wait_sum[WaitWidth-1:0];
            end
         end else if (!best_found_ff || cand_before) begin
            best_found_in = 1'b1;
            best_idx_in   = idx_q_ff;
            best_id_in    = rd_id_ff;
            best_prio_in  = rd_prio_ff;
            best_burst_in = rd_burst_ff;
            best_seq_in   = rd_seq_ff;
         end
      end

      if (cmd.enq_commit) begin
         if (tpr_ff >= PrioLimit) res_status_in = ST_BAD_PRIO;
         else if (!free_found) res_status_in = ST_FULL;
         else begin
            wr_all             = 1'b1;
            wr_addr            = free_idx;
            valid_in[free_idx] = 1'b1;
            nseq_in            = nseq_ff + 8'd1;
         end
      end

      if (cmd.deq_commit) begin
         if (best_found_ff) begin
            res_id_in             = best_id_ff;
            res_prio_in           = best_prio_ff;
            res_burst_in          = best_burst_ff;
            res_level_in          = level_of(best_prio_ff, floor1_ff, floor2_ff);
            valid_in[best_idx_ff] = 1'b0;
         end else begin
            res_status_in = ST_EMPTY;
         end
      end

      if (cmd.promote_commit) begin
         wr_prio_seq          = 1'b1;
         wr_addr              = best_idx_ff;
         wr_prio_val          = (prio_sum > (PrioWidth + 1)'(cap_eff)) ? cap_eff
                                : prio_sum[PrioWidth-1:0];
         pend_in[best_idx_ff] = 1'b0;
         nseq_in              = nseq_ff + 8'd1;
         res_count_in         = res_count_ff + 5'd1;
      end
   end

   // table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_all) begin
         mem_id[wr_addr]    <= tid_ff;
         mem_burst[wr_addr] <= tbu_ff;
      end
      if (wr_all || wr_wait) mem_wait[wr_addr] <= wr_wait_val;
      if (wr_all || wr_prio_seq) begin
         mem_prio[wr_addr] <= wr_prio_val;
         mem_seq[wr_addr]  <= wr_seq_val;
      end
      rd_id_ff    <= mem_id[rd_idx];
      rd_prio_ff  <= mem_prio[rd_idx];
      rd_burst_ff <= mem_burst[rd_idx];
      rd_wait_ff  <= mem_wait[rd_idx];
      rd_seq_ff   <= mem_seq[rd_idx];
   end

   always_ff @(posedge clock) begin
      idx_q_ff      <= rd_idx;
      mode_q_ff     <= cmd.mode;
      best_idx_ff   <= best_idx_in;
      best_id_ff    <= best_id_in;
      best_prio_ff  <= best_prio_in;
      best_burst_ff <= best_burst_in;
      best_seq_ff   <= best_seq_in;
      res_id_ff     <= res_id_in;
      res_prio_ff   <= res_prio_in;
      res_burst_ff  <= res_burst_in;
      res_level_ff  <= res_level_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      if (cmd.load) begin
         tid_ff  <= in_id;
         tpr_ff  <= in_priority;
         tbu_ff  <= in_burst;
         base_ff <= nseq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         pend_ff       <= '0;
         nseq_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         step_ff       <= 8'd100;
         thr_ff        <= 10'd400;
         boost_ff      <= 6'd10;
         cap_ff        <= 8'd149;
         floor1_ff     <= 8'd100;
         floor2_ff     <= 8'd50;
      end else begin
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         nseq_ff       <= nseq_in;
         rd_vld_ff     <= cmd.rd_en;
         best_found_ff <= best_found_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_AGING_STEP:      step_ff   <= csr_wdata[7:0];
               CSR_AGING_THRESHOLD: thr_ff    <= csr_wdata[9:0];
               CSR_PRIORITY_BOOST:  boost_ff  <= csr_wdata[5:0];
               CSR_PRIORITY_CAP:    cap_ff    <= csr_wdata[7:0];
               CSR_LEVEL_ONE_FLOOR: floor1_ff <= csr_wdata[7:0];
               CSR_LEVEL_TWO_FLOOR: floor2_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

[rtl/multilevel_ready_queue_scheduler_core.sv]
// top level of the multilevel ready queue scheduler with aging
// depends on mlrq_pkg, mlrq_req_if, mlrq_rsp_if, mlrq_ctrl, mlrq_dpath
//
// usage
//  - req_chan carries one transaction: op (enqueue, dequeue, age tick) plus
//    the task id, priority and burst used by an enqueue
//  - rsp_chan returns exactly one transaction per request: status, the
//    dequeued task's fields and level, and the count of promoted tasks
//  - csr_we/csr_index/csr_wdata write the aging and level registers; the user
//    writes them only while the block is idle; the block does not enforce it
//  - one request is handled at a time; req_chan.ready is high only when idle
//  - steps from acceptance to rsp_chan.valid: an enqueue commits in S_ENQ;
//    an unused op goes straight to the response; a dequeue scans every
//    table slot (one table slot read per cycle), then commits; an age tick
//    makes one wait pass, then one selection scan per promotion so
//    promotions take sequence numbers in queue order
//  - the single table read port sets the pace: one slot per cycle
//  - a stalled rsp_chan holds the result and keeps req_chan.ready low
//  - reset is synchronous; it empties the table, restores register defaults
//    and clears the sequence counter; no clearing pass is needed
module multilevel_ready_queue_scheduler_core #(
   parameter int unsigned TABLE_ENTRIES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mlrq_req_if.sink                              req_chan,
   mlrq_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [mlrq_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [mlrq_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import mlrq_pkg::*;

   localparam int unsigned IdxWidth = $clog2(TABLE_ENTRIES);

   cmd_type             cmd;
   stat_type            stat;
   logic [IdxWidth-1:0] rd_idx;

   // sequencer: owns handshakes and the scan counter
   mlrq_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .stat      (stat)
   );

   // table, ordering compare and result registers
   mlrq_dpath #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rd_idx       (rd_idx),
      .stat         (stat),
      .in_id        (req_chan.task_id),
      .in_priority  (req_chan.task_priority),
      .in_burst     (req_chan.task_burst),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .res_status   (rsp_chan.status),
      .res_id       (rsp_chan.out_id),
      .res_priority (rsp_chan.out_priority),
      .res_burst    (rsp_chan.out_burst),
      .res_level    (rsp_chan.out_level),
      .res_count    (rsp_chan.promoted_count)
   );

endmodule

[rtl/mlrq_checker.sv]
// port-level checks of the ready queue scheduler, bound to the top level
// depends on mlrq_pkg and multilevel_ready_queue_scheduler_core
module mlrq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mlrq_pkg::status_type  status,
   input logic [1:0]            out_level,
   input logic [4:0]            promoted_count
);
   import mlrq_pkg::*;

   // one transaction in flight: never taking a request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after acceptance");

   a_level_means_dequeue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_level != 2'd0) |-> (status == ST_OK && promoted_count == 5'd0))
      else $error("dequeued level with bad status or promotions");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)))
      else $error("stalled response changed");

endmodule

bind multilevel_ready_queue_scheduler_core mlrq_checker u_mlrq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .status         (rsp_chan.status),
   .out_level      (rsp_chan.out_level),
   .promoted_count (rsp_chan.promoted_count)
);
